// ===== design/plf_pkg.sv =====
package plf_pkg;

    localparam int MAX_LIMIT   = 311;
    localparam int TABLE_DEPTH = 64;
    localparam int DATA_W      = 9;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int DIV_STEPS   = DATA_W;
    localparam int STEP_W      = $clog2(DIV_STEPS + 1);
    localparam int SQ_W        = 2 * DATA_W;

    typedef logic [DATA_W-1:0] value_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_TEST,
        ST_DIV,
        ST_FOUND,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic   start;
        value_t dividend;
        value_t divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic zero;
    } div_rsp_t;

endpackage

// ===== design/plf_if.sv =====
interface plf_req_if
    import plf_pkg::*;
();
    logic   valid;
    logic   ready;
    value_t limit;

    modport source (output valid, output limit, input ready);
    modport sink (input valid, input limit, output ready);
endinterface

interface plf_rsp_if
    import plf_pkg::*;
();
    logic   valid;
    logic   ready;
    value_t prime;
    logic   last;
    logic   invalid;

    modport source (output valid, output prime, output last, output invalid, input ready);
    modport sink (input valid, input prime, input last, input invalid, output ready);
endinterface

// ===== design/prime_list_by_found_primes_top.sv =====
// Prime list generator, trial division by the primes already found.
// req channel: one transaction carries a limit N (values above 311 are
//   clamped). ready is high only while no request is in progress.
// rsp channel: every prime p with 2 <= p <= N in ascending order, one per
//   transaction; the final one has last set. A limit of 0 or 1 gives a
//   single transaction with prime = 0, last = 1, invalid = 1.
// Search: each odd candidate is checked against the stored primes p with
//   p*p <= candidate. A trial is a table read, a square test and then the
//   serial remainder unit, which runs until it raises its done flag.
//   Results leave through one output register; a new prime is held back
//   until the previous one is taken, so a stalled receiver stalls the
//   search. The next request is accepted while the last result waits.
// Reset: clears the control state and the output valid; the prime table
//   needs no clearing since each request rewrites it before reading.
module prime_list_by_found_primes_top
    import plf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    plf_req_if.sink  req,
    plf_rsp_if.source rsp
);

    state_t   state_reg, state_next;
    value_t   n_reg, n_next;
    value_t   cand_reg, cand_next;
    cnt_t     count_reg, count_next;
    idx_t     k_reg, k_next;
    value_t   pend_reg, pend_next;
    logic     pend_inv_reg, pend_inv_next;
    logic     out_valid_reg, out_valid_next;
    value_t   out_prime_reg, out_prime_next;
    logic     out_last_reg, out_last_next;
    logic     out_inv_reg, out_inv_next;

    value_t   mem [TABLE_DEPTH];
    value_t   rd_data_reg;
    logic     wr_en;
    idx_t     wr_addr;
    value_t   wr_data;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic     accept;
    logic     out_free;
    value_t   limit_clamped;
    logic [SQ_W-1:0] sq;
    logic     sq_above;
    logic     k_at_end;
    logic     more;

    assign accept        = req.valid && req.ready;
    assign out_free      = !out_valid_reg || rsp.ready;
    assign limit_clamped = (req.limit > value_t'(MAX_LIMIT)) ? value_t'(MAX_LIMIT) : req.limit;
    assign sq            = rd_data_reg * rd_data_reg;
    assign sq_above      = sq > SQ_W'(cand_reg);
    assign k_at_end      = (CNT_W'(k_reg) + CNT_W'(1)) == count_reg;
    assign more          = (cand_reg <= n_reg) && (count_reg < CNT_W'(TABLE_DEPTH));

    plf_rem u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (limit_clamped < value_t'(2)) ? ST_FINAL : ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = more ? ST_READ : ST_FINAL;
            end
            ST_READ:
            begin
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                state_next = sq_above ? ST_FOUND : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    priority if (div_rsp.zero)
                    begin
                        state_next = ST_CHECK;
                    end
                    else if (k_at_end)
                    begin
                        state_next = ST_FOUND;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_FOUND:
            begin
                if (out_free)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        n_next         = n_reg;
        cand_next      = cand_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        pend_next      = pend_reg;
        pend_inv_next  = pend_inv_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_prime_next = out_prime_reg;
        out_last_next  = out_last_reg;
        out_inv_next   = out_inv_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = value_t'(2);
        div_req        = '{start: 1'b0, dividend: cand_reg, divisor: rd_data_reg};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    n_next     = limit_clamped;
                    cand_next  = value_t'(3);
                    if (limit_clamped < value_t'(2))
                    begin
                        count_next    = '0;
                        pend_next     = '0;
                        pend_inv_next = 1'b1;
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        count_next    = CNT_W'(1);
                        pend_next     = value_t'(2);
                        pend_inv_next = 1'b0;
                    end
                end
            end
            ST_CHECK:
            begin
                k_next = '0;
            end
            ST_READ:
            begin
            end
            ST_TEST:
            begin
                div_req.start = !sq_above;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.zero)
                    begin
                        cand_next = cand_reg + value_t'(2);
                    end
                    else if (!k_at_end)
                    begin
                        k_next = k_reg + idx_t'(1);
                    end
                end
            end
            ST_FOUND:
            begin
                if (out_free)
                begin
                    wr_en          = 1'b1;
                    wr_addr        = count_reg[IDX_W-1:0];
                    wr_data        = cand_reg;
                    count_next     = count_reg + CNT_W'(1);
                    out_valid_next = 1'b1;
                    out_prime_next = pend_reg;
                    out_last_next  = 1'b0;
                    out_inv_next   = 1'b0;
                    pend_next      = cand_reg;
                    cand_next      = cand_reg + value_t'(2);
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_prime_next = pend_reg;
                    out_last_next  = 1'b1;
                    out_inv_next   = pend_inv_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cand_reg      <= value_t'(3);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cand_reg      <= cand_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        k_reg         <= k_next;
        pend_reg      <= pend_next;
        pend_inv_reg  <= pend_inv_next;
        out_prime_reg <= out_prime_next;
        out_last_reg  <= out_last_next;
        out_inv_reg   <= out_inv_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[k_reg];
    end

    assign req.ready   = (state_reg == ST_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.prime   = out_prime_reg;
    assign rsp.last    = out_last_reg;
    assign rsp.invalid = out_inv_reg;

endmodule

// ===== design/plf_rem.sv =====
module plf_rem
    import plf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [DATA_W:0]     rem_reg, rem_next;
    value_t              dvd_reg, dvd_next;
    value_t              dvs_reg, dvs_next;
    logic [DATA_W:0]     trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg[DATA_W-1:0], dvd_reg[DATA_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIV_STEPS);
            rem_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
            end
            else
            begin
                rem_next = trial;
            end
            dvd_next  = {dvd_reg[DATA_W-2:0], 1'b0};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.zero = (rem_reg == '0);

endmodule
